@@ design/ifp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types and constants for the IMU serial frame parser: byte codes,
// packet kinds, register indexes and the frame record passed front to back.
// ----------------------------------------------------------------------------
package ifp_pkg;

  // Serial frame byte codes
  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;

  // Byte positions within a frame
  localparam logic [3:0] KindPos   = 4'd1;
  localparam logic [3:0] FirstData = 4'd2;
  localparam logic [3:0] LastData  = 4'd9;
  localparam logic [3:0] SumPos    = 4'd10;

  // Result packet kinds
  localparam logic [1:0] KindAccel = 2'd0;
  localparam logic [1:0] KindRate  = 2'd1;
  localparam logic [1:0] KindAngle = 2'd2;

  // Configuration register indexes and reset values
  localparam logic CfgAccelFs = 1'b0;
  localparam logic CfgGyroFs  = 1'b1;
  localparam logic [4:0]  AccelFsReset = 5'd16;
  localparam logic [10:0] GyroFsReset  = 11'd2000;

  // Angle range in degrees
  localparam logic [10:0] AngleRange = 11'd180;

  // Divide by 17: floor(m / 17) == (m * Recip17) >> Recip17Shift for m < 2^20
  localparam logic [15:0] Recip17      = 16'd61681;
  localparam int          Recip17Shift = 20;

  // Temperature offset in hundredths of a degree
  localparam logic signed [14:0] TempOffset = 15'sd3653;

  // Frame queue geometry
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One good frame as handed from the front to the back
  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  raw_x;
    logic signed [15:0]  raw_y;
    logic signed [15:0]  raw_z;
    logic signed [15:0]  raw_t;
  } frame_t;

endpackage

@@ design/imu_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser
// Assembles 11-byte serial IMU frames, checks the sum and type, and emits the
// three axes scaled to 2^-16 units plus temperature in hundredths of a degree.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o     | rx_byte_i
//  out     | out_valid_o / out_stall_i   | packet_kind_o, axis_*_o, temperature_o
//  cfg     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
//  One byte per cycle is taken; the assembler only stalls when the two-entry
//  frame queue is full.
//  A result passes from the edge that takes its checksum byte through the
//  queue write on that edge, then the product stage, then the divide-by-17
//  stage with the output register.
//  Reset clears byte count, sum, queue and pipeline valids; registers return
//  to 16 g and 2000 deg/s. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module imu_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         packet_kind_o,
  output logic signed [27:0] axis_x_o,
  output logic signed [27:0] axis_y_o,
  output logic signed [27:0] axis_z_o,
  output logic signed [14:0] temperature_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [10:0]        cfg_data_i
);
  import ifp_pkg::*;

  logic        accept;
  logic        push, pop, q_full, q_empty;
  frame_t      push_frame, head_frame;
  logic [4:0]  accel_fs_q;
  logic [10:0] gyro_fs_q;

  // Hold input while the frame queue is full
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_fs_q <= AccelFsReset;
      gyro_fs_q  <= GyroFsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgAccelFs: accel_fs_q <= cfg_data_i[4:0];
        CfgGyroFs:  gyro_fs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ifp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .frame_o   (push_frame)
  );

  ifp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_frame),
    .pop_i   (pop),
    .rdata_o (head_frame),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ifp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (!q_empty),
    .frame_i       (head_frame),
    .pop_o         (pop),
    .accel_fs_i    (accel_fs_q),
    .gyro_fs_i     (gyro_fs_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packet_kind_o (packet_kind_o),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .temperature_o (temperature_o)
  );

endmodule

@@ design/ifp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_front
// Frame assembler: counts bytes, keeps the running sum, stores the payload and
// pushes one record for each frame with a good sum and a known type.
// ----------------------------------------------------------------------------
module ifp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     rx_byte_i,
  output logic           push_o,
  output ifp_pkg::frame_t frame_o
);
  import ifp_pkg::*;

  logic [3:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] type_q;
  logic [7:0] data_q [8];
  logic [2:0] data_idx;
  logic       is_data;
  logic       kind_ok;
  logic [1:0] kind;

  // Track position and checksum within the frame
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept_i) begin
      if (count_q == 4'd0) begin
        if (rx_byte_i == HdrByte) begin
          count_d = 4'd1;
          sum_d   = rx_byte_i;
        end
      end else if (count_q < SumPos) begin
        count_d = count_q + 4'd1;
        sum_d   = sum_q + rx_byte_i;
      end else begin
        count_d = 4'd0;
        sum_d   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      sum_q   <= 8'd0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Store type and payload bytes
  assign is_data  = (count_q >= FirstData) && (count_q <= LastData);
  assign data_idx = 3'(count_q - FirstData);

  always_ff @(posedge clk_i) begin
    if (accept_i && count_q == KindPos) begin
      type_q <= rx_byte_i;
    end
    if (accept_i && is_data) begin
      data_q[data_idx] <= rx_byte_i;
    end
  end

  // Classify the frame type
  always_comb begin
    kind_ok = 1'b1;
    case (type_q)
      TypeAccel: kind = KindAccel;
      TypeRate:  kind = KindRate;
      TypeAngle: kind = KindAngle;
      default: begin
        kind    = KindAccel;
        kind_ok = 1'b0;
      end
    endcase
  end

  // Push on the checksum byte of a good frame
  assign push_o = accept_i && (count_q == SumPos) && (sum_q == rx_byte_i) && kind_ok;

  assign frame_o.kind  = kind;
  assign frame_o.raw_x = {data_q[1], data_q[0]};
  assign frame_o.raw_y = {data_q[3], data_q[2]};
  assign frame_o.raw_z = {data_q[5], data_q[4]};
  assign frame_o.raw_t = {data_q[7], data_q[6]};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SumPos)
    else $error("byte count beyond checksum position");

  a_push_on_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (count_q == SumPos) && (sum_q == rx_byte_i))
    else $error("frame pushed without matching checksum");

endmodule

@@ design/ifp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_queue
// Short FIFO of frame records between the assembler and the scaling pipeline.
// ----------------------------------------------------------------------------
module ifp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ifp_pkg::frame_t wdata_i,
  input  logic            pop_i,
  output ifp_pkg::frame_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import ifp_pkg::*;

  frame_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full frame queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty frame queue");

endmodule

@@ design/ifp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_back
// Scaling pipeline: stage A multiplies axes by twice the full scale and forms
// raw*5 for temperature; stage B divides by 17, adds the offset and holds the
// result for the output channel.
// ----------------------------------------------------------------------------
module ifp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ifp_pkg::frame_t    frame_i,
  output logic               pop_o,
  input  logic [4:0]         accel_fs_i,
  input  logic [10:0]        gyro_fs_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         packet_kind_o,
  output logic signed [27:0] axis_x_o,
  output logic signed [27:0] axis_y_o,
  output logic signed [27:0] axis_z_o,
  output logic signed [14:0] temperature_o
);
  import ifp_pkg::*;

  logic               a_ready, b_ready;
  logic [10:0]        fs;
  logic signed [12:0] fs2;
  logic signed [28:0] px, py, pz;
  logic signed [18:0] t5;
  logic               a_valid_q;
  logic [1:0]         a_kind_q;
  logic signed [27:0] a_x_q, a_y_q, a_z_q;
  logic               a_tneg_q;
  logic [17:0]        a_tmag_q;
  logic [33:0]        tprod;
  logic [13:0]        tquot;
  logic signed [14:0] tsigned;
  logic               b_valid_q;
  logic [1:0]         b_kind_q;
  logic signed [27:0] b_x_q, b_y_q, b_z_q;
  logic signed [14:0] b_t_q;

  assign b_ready = !b_valid_q || !out_stall_i;
  assign a_ready = !a_valid_q || b_ready;
  assign pop_o   = in_valid_i && a_ready;

  // Select full scale by packet kind
  always_comb begin
    case (frame_i.kind)
      KindAccel: fs = {6'd0, accel_fs_i};
      KindRate:  fs = gyro_fs_i;
      KindAngle: fs = AngleRange;
      default:   fs = '0;
    endcase
  end

  assign fs2 = $signed({1'b0, fs, 1'b0});
  assign px  = frame_i.raw_x * fs2;
  assign py  = frame_i.raw_y * fs2;
  assign pz  = frame_i.raw_z * fs2;
  assign t5  = (19'(frame_i.raw_t) <<< 2) + 19'(frame_i.raw_t);

  // Stage A: axis products and temperature magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_kind_q <= frame_i.kind;
      a_x_q    <= px[27:0];
      a_y_q    <= py[27:0];
      a_z_q    <= pz[27:0];
      a_tneg_q <= t5[18];
      a_tmag_q <= t5[18] ? 18'(-t5) : 18'(t5);
    end
  end

  // Stage B: divide by 17, restore sign, add offset
  assign tprod   = 34'(a_tmag_q) * 34'(Recip17);
  assign tquot   = tprod[Recip17Shift +: 14];
  assign tsigned = a_tneg_q ? -$signed({1'b0, tquot}) : $signed({1'b0, tquot});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_kind_q <= a_kind_q;
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_z_q    <= a_z_q;
      b_t_q    <= tsigned + TempOffset;
    end
  end

  assign out_valid_o   = b_valid_q;
  assign packet_kind_o = b_kind_q;
  assign axis_x_o      = b_x_q;
  assign axis_y_o      = b_y_q;
  assign axis_z_o      = b_z_q;
  assign temperature_o = b_t_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU serial frame parser. It streams bytes made of
// well-formed frames, bad sums, unknown types and line noise. It predicts each
// decoded reading from its own copy of the frame state and the range settings,
// and compares every reading that leaves the block against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ifp_pkg::*;

  localparam int PhaseBytes    = 120;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 2000;

  typedef struct {
    logic [1:0]         kind;
    logic signed [27:0] axis_x;
    logic signed [27:0] axis_y;
    logic signed [27:0] axis_z;
    logic signed [14:0] temperature;
  } imu_reading_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         packet_kind_o;
  logic signed [27:0] axis_x_o;
  logic signed [27:0] axis_y_o;
  logic signed [27:0] axis_z_o;
  logic signed [14:0] temperature_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [10:0]        cfg_data_i;

  // Serial byte stream waiting to go out, and readings the frames will produce
  logic [7:0]   tx_bytes[$];
  imu_reading_t expected_readings[$];
  imu_reading_t got_reading;

  // Shadow of the parser state and range registers
  logic [3:0]  frame_count = '0;
  logic [7:0]  frame_sum   = '0;
  logic [7:0]  frame_buf[10];
  logic [4:0]  accel_fs    = AccelFsReset;
  logic [10:0] gyro_fs     = GyroFsReset;

  logic in_fire    = 1'b0;
  logic quiet_run  = 1'b0;
  int   in_gap     = 0;
  int   out_hold   = 0;
  int   idle_cycles = 0;
  int   error_count = 0;

  imu_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packet_kind_o (packet_kind_o),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .temperature_o (temperature_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Generate the 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Pick an idle length: mostly none or short, a few long, with quiet runs
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) quiet_run = ~quiet_run;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Advance the frame state by one byte and record the reading it completes
  function automatic void predict_rx_byte(input logic [7:0] b);
    imu_reading_t       r;
    int                 fs;
    logic signed [15:0] raw[4];
    if (frame_count == 0 && b != HdrByte) return;
    if (frame_count < SumPos) begin
      frame_buf[frame_count] = b;
      frame_sum += b;
      frame_count++;
      return;
    end
    frame_count = '0;
    if (frame_sum != b) begin
      frame_sum = '0;
      return;
    end
    frame_sum = '0;
    case (frame_buf[KindPos])
      TypeAccel: begin
        r.kind = KindAccel;
        fs = int'(accel_fs);
      end
      TypeRate: begin
        r.kind = KindRate;
        fs = int'(gyro_fs);
      end
      TypeAngle: begin
        r.kind = KindAngle;
        fs = int'(AngleRange);
      end
      default: return;
    endcase
    for (int i = 0; i < 4; i++) begin
      raw[i] = {frame_buf[FirstData + 2 * i + 1], frame_buf[FirstData + 2 * i]};
    end
    r.axis_x = 28'(int'(raw[0]) * 2 * fs);
    r.axis_y = 28'(int'(raw[1]) * 2 * fs);
    r.axis_z = 28'(int'(raw[2]) * 2 * fs);
    r.temperature = 15'((int'(raw[3]) * 5) / 17 + int'(TempOffset));
    expected_readings.push_back(r);
  endfunction

  // Queue one frame; a nonzero sum_flip corrupts the checksum byte
  function automatic void queue_frame(input logic [7:0] kind_byte,
                                      input logic [15:0] x, y, z, t,
                                      input logic [7:0] sum_flip);
    logic [7:0] body[10];
    logic [7:0] sum;
    body = '{HdrByte, kind_byte, x[7:0], x[15:8], y[7:0], y[15:8],
             z[7:0], z[15:8], t[7:0], t[15:8]};
    sum = '0;
    foreach (body[i]) begin
      sum += body[i];
      tx_bytes.push_back(body[i]);
    end
    tx_bytes.push_back(sum ^ sum_flip);
  endfunction

  // Raw sensor word, leaning on the extremes
  function automatic logic [15:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h7FFF;
    if (r < 20) return 16'h8000;
    if (r < 25) return 16'h0000;
    return 16'($urandom);
  endfunction

  // Queue a random frame plus occasional noise; return the bytes added
  function automatic int queue_random_frame();
    logic [7:0] kind_byte;
    logic [7:0] flip;
    logic [7:0] junk;
    int         r;
    int         n;
    int         start;
    start = tx_bytes.size();
    r = $urandom_range(0, 99);
    if (r < 28) kind_byte = TypeAccel;
    else if (r < 56) kind_byte = TypeRate;
    else if (r < 84) kind_byte = TypeAngle;
    else kind_byte = 8'($urandom);
    flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    queue_frame(kind_byte, rand_word(), rand_word(), rand_word(), rand_word(), flip);
    // Drop line noise between frames, or a stray header that shifts the framing
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_bytes.push_back(HdrByte);
    end else if (r < 23) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        junk = 8'($urandom);
        if (junk == HdrByte) junk ^= 8'h01;
        tx_bytes.push_back(junk);
      end
    end
    return tx_bytes.size() - start;
  endfunction

  // Write one range register through the config channel
  task automatic write_reg(input logic index, input logic [10:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CfgAccelFs) accel_fs = value[4:0];
    else gyro_fs = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every byte is taken and every reading is back, then settle
  task automatic wait_drained();
    while (tx_bytes.size() != 0 || in_valid_i || expected_readings.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Set both ranges, then stream random frames under them
  task automatic run_phase(input logic [4:0] accel, input logic [10:0] gyro);
    int queued;
    write_reg(CfgAccelFs, {6'($urandom), accel});
    write_reg(CfgGyroFs, gyro);
    queued = 0;
    while (queued < PhaseBytes) queued += queue_random_frame();
    wait_drained();
  endtask

  // Byte driver: change at the falling edge, hold while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (tx_bytes.size() != 0) begin
        rx_byte_i  <= tx_bytes.pop_front();
        in_valid_i <= 1'b1;
        in_gap     <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Reading stall: random stretches of back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold <= out_hold - 1;
      end else begin
        out_stall_i <= 1'b0;
        out_hold <= pick_gap();
      end
    end
  end

  // Monitor: predict on each byte transaction, check each reading transaction
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) predict_rx_byte(rx_byte_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $error("reading with no frame pending: kind %0d", packet_kind_o);
        error_count++;
      end else begin
        got_reading = expected_readings.pop_front();
        if (packet_kind_o !== got_reading.kind) begin
          $error("packet_kind expected %0d got %0d", got_reading.kind, packet_kind_o);
          error_count++;
        end
        if (axis_x_o !== got_reading.axis_x) begin
          $error("axis_x expected %0d got %0d", got_reading.axis_x, axis_x_o);
          error_count++;
        end
        if (axis_y_o !== got_reading.axis_y) begin
          $error("axis_y expected %0d got %0d", got_reading.axis_y, axis_y_o);
          error_count++;
        end
        if (axis_z_o !== got_reading.axis_z) begin
          $error("axis_z expected %0d got %0d", got_reading.axis_z, axis_z_o);
          error_count++;
        end
        if (temperature_o !== got_reading.temperature) begin
          $error("temperature expected %0d got %0d", got_reading.temperature,
                 temperature_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("imu_frame_parser regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequence: reset, directed frames, then random phases over several ranges
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgAccelFs;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle non-header bytes are ignored
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    // Extreme raw words for the accel and rate kinds, at the reset ranges
    queue_frame(TypeAccel, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 8'h00);
    queue_frame(TypeRate, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 8'h00);
    // Header bytes inside the payload are plain data
    queue_frame(TypeAngle, 16'h0055, 16'h5555, 16'h1234, 16'h0000, 8'h00);
    // Bad checksum, then unknown types with good sums
    queue_frame(TypeAccel, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 8'h80);
    queue_frame(8'h54, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'h00);
    queue_frame(8'h50, 16'hAAAA, 16'hBBBB, 16'hCCCC, 16'hDDDD, 8'h00);
    wait_drained();

    run_phase(5'd2, 11'd250);
    run_phase(5'd31, 11'd2047);
    run_phase(5'd0, 11'd0);
    run_phase(5'd16, 11'd2000);
    run_phase(5'($urandom), 11'($urandom));
    run_phase(5'($urandom), 11'($urandom));

    if (error_count == 0) begin
      $display("imu_frame_parser regression: pass");
    end else begin
      $display("imu_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
